>>> hdl/vkms_pkg.sv
// Package for the velocity keyboard matrix scanner.
// Holds payload and control types, sizes, register codes and the note, velocity and channel ROMs.
// No dependencies.
package vkms_pkg;

   localparam int NUM_ROWS    = 17;
   localparam int NUM_COLUMNS = 24;
   localparam int TIME_WIDTH  = 32;
   localparam int ROW_W       = 5;
   localparam int COL_W       = 5;
   localparam int PAIR_COUNT  = 96;
   localparam int PAIR_W      = 7;
   localparam int PIN_W       = 8;
   localparam int CFG_W       = 16;
   localparam int QUOT_W      = 7;
   localparam int DIVIDEND_W  = CFG_W + QUOT_W;
   localparam int DV_W        = CFG_W + QUOT_W - 1;
   localparam int CNT_W       = 3;
   localparam int CSR_INDEX_W = 2;

   localparam logic [ROW_W-1:0] CHANNEL_ROW   = 5'd16;
   localparam logic [COL_W-1:0] FIRST_CH_COL  = 5'd8;
   localparam logic [6:0]       VEL_IDX_MAX   = 7'd127;
   localparam logic [6:0]       VEL_IDX_MIN   = 7'd1;
   localparam logic [6:0]       QUOT_SAT      = 7'd126;
   localparam logic [7:0]       NOTE_MAX      = 8'd127;

   localparam logic [CSR_INDEX_W-1:0] CSR_FASTEST = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOWEST = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIXED   = 2'd2;

   typedef struct packed {
      logic [ROW_W-1:0]       row_index;
      logic [NUM_COLUMNS-1:0] contact_bits;
      logic [TIME_WIDTH-1:0]  time_ms;
   } req_type;

   typedef struct packed {
      logic [6:0] key_note;
      logic [6:0] velocity_out;
      logic [3:0] midi_channel;
      logic       last_of_row;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_READ,
      ST_DIV,
      ST_EMIT,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [CFG_W-1:0]      divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quotient;
   } div_rsp_type;

   localparam logic [6:0] VEL_ROM [128] = '{
      7'h01, 7'h01, 7'h01, 7'h01, 7'h01, 7'h01, 7'h01, 7'h01,
      7'h01, 7'h01, 7'h01, 7'h01, 7'h01, 7'h01, 7'h01, 7'h01,
      7'h01, 7'h01, 7'h01, 7'h02, 7'h02, 7'h02, 7'h02, 7'h02,
      7'h02, 7'h02, 7'h02, 7'h02, 7'h02, 7'h03, 7'h03, 7'h03,
      7'h03, 7'h03, 7'h03, 7'h03, 7'h03, 7'h04, 7'h04, 7'h04,
      7'h04, 7'h04, 7'h04, 7'h05, 7'h05, 7'h05, 7'h05, 7'h06,
      7'h06, 7'h06, 7'h06, 7'h07, 7'h07, 7'h07, 7'h07, 7'h08,
      7'h08, 7'h08, 7'h09, 7'h09, 7'h09, 7'h0a, 7'h0a, 7'h0b,
      7'h0b, 7'h0b, 7'h0c, 7'h0c, 7'h0d, 7'h0d, 7'h0e, 7'h0f,
      7'h0f, 7'h10, 7'h10, 7'h11, 7'h12, 7'h12, 7'h13, 7'h14,
      7'h15, 7'h16, 7'h16, 7'h17, 7'h18, 7'h19, 7'h1a, 7'h1b,
      7'h1c, 7'h1d, 7'h1f, 7'h20, 7'h21, 7'h22, 7'h24, 7'h25,
      7'h27, 7'h28, 7'h2a, 7'h2b, 7'h2d, 7'h2f, 7'h31, 7'h33,
      7'h35, 7'h37, 7'h39, 7'h3b, 7'h3d, 7'h40, 7'h42, 7'h45,
      7'h48, 7'h4a, 7'h4d, 7'h50, 7'h54, 7'h57, 7'h5a, 7'h5e,
      7'h61, 7'h65, 7'h69, 7'h6d, 7'h72, 7'h76, 7'h7b, 7'h7f
   };

   localparam logic [7:0] NOTE_ROM [192] = '{
      8'd39, 8'd33, 8'd40, 8'd35, 8'd37, 8'd36, 8'd38, 8'd33,
      8'd35, 8'd37, 8'd36, 8'd38, 8'd33, 8'd39, 8'd34, 8'd40,
      8'd38, 8'd34, 8'd39, 8'd34, 8'd40, 8'd35, 8'd37, 8'd36,
      8'd93, 8'd86, 8'd79, 8'd72, 8'd65, 8'd58, 8'd51, 8'd44,
      8'd90, 8'd83, 8'd76, 8'd69, 8'd62, 8'd55, 8'd48, 8'd41,
      8'd94, 8'd87, 8'd80, 8'd73, 8'd66, 8'd59, 8'd52, 8'd45,
      8'd91, 8'd84, 8'd77, 8'd70, 8'd63, 8'd56, 8'd49, 8'd42,
      8'd95, 8'd88, 8'd81, 8'd74, 8'd67, 8'd60, 8'd53, 8'd46,
      8'd92, 8'd85, 8'd78, 8'd71, 8'd64, 8'd57, 8'd50, 8'd43,
      8'd96, 8'd89, 8'd82, 8'd75, 8'd68, 8'd61, 8'd54, 8'd47,
      8'd93, 8'd86, 8'd79, 8'd72, 8'd65, 8'd58, 8'd51, 8'd44,
      8'd90, 8'd83, 8'd76, 8'd69, 8'd62, 8'd55, 8'd48, 8'd41,
      8'd94, 8'd87, 8'd80, 8'd73, 8'd66, 8'd59, 8'd52, 8'd45,
      8'd91, 8'd84, 8'd77, 8'd70, 8'd63, 8'd56, 8'd49, 8'd42,
      8'd95, 8'd88, 8'd81, 8'd74, 8'd67, 8'd60, 8'd53, 8'd46,
      8'd92, 8'd85, 8'd78, 8'd71, 8'd64, 8'd57, 8'd50, 8'd43,
      8'd96, 8'd89, 8'd82, 8'd75, 8'd68, 8'd61, 8'd54, 8'd47,
      8'd93, 8'd86, 8'd79, 8'd72, 8'd65, 8'd58, 8'd51, 8'd44,
      8'd90, 8'd83, 8'd76, 8'd69, 8'd62, 8'd55, 8'd48, 8'd41,
      8'd94, 8'd87, 8'd80, 8'd73, 8'd66, 8'd59, 8'd52, 8'd45,
      8'd91, 8'd84, 8'd77, 8'd70, 8'd63, 8'd56, 8'd49, 8'd42,
      8'd95, 8'd88, 8'd81, 8'd74, 8'd67, 8'd60, 8'd53, 8'd46,
      8'd92, 8'd85, 8'd78, 8'd71, 8'd64, 8'd57, 8'd50, 8'd43,
      8'd96, 8'd89, 8'd82, 8'd75, 8'd68, 8'd61, 8'd54, 8'd47
   };

   localparam logic [3:0] CHAN_ROM [16] = '{
      4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0,
      4'd15, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd8
   };

endpackage

>>> hdl/vkms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Width and depth set by parameters; no package dependency.
module vkms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 96
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/vkms_div.sv
// Bit-serial restoring divider producing a 7-bit quotient, one bit per cycle.
// Depends on vkms_pkg for operand widths and the request and response structs.
module vkms_div (
   input  logic                  clock,
   input  logic                  reset,
   input  vkms_pkg::div_req_type div_req,
   output vkms_pkg::div_rsp_type div_rsp
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [vkms_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic [vkms_pkg::DIVIDEND_W-1:0] rem_ff, rem_in;
   logic [vkms_pkg::DV_W-1:0]       dv_ff, dv_in;
   logic [vkms_pkg::QUOT_W-1:0]     q_ff, q_in;
   logic                            ge;

   assign ge = rem_ff >= {1'b0, dv_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dv_in   = dv_ff;
      q_in    = q_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = vkms_pkg::CNT_W'(vkms_pkg::QUOT_W);
         rem_in  = div_req.dividend;
         dv_in   = {div_req.divisor, {(vkms_pkg::QUOT_W-1){1'b0}}};
         q_in    = '0;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - {1'b0, dv_ff};
         end
         q_in   = {q_ff[vkms_pkg::QUOT_W-2:0], ge};
         dv_in  = dv_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == vkms_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dv_ff  <= dv_in;
      q_ff   <= q_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = q_ff;

endmodule

>>> hdl/velocity_keyboard_matrix_scanner_unit.sv
// Velocity keyboard matrix scanner: one row request in, note events out.
// Each accepted request is walked column by column in the scan state; a note-off goes on to the
// emit state, a note-on to the capture read, the bit-serial divide if needed, then the emit state.
// Each event is held until the next one or the flush, which marks it last of row.
// One request at a time: a new row is accepted only in the idle state; output stalls can hold the scan.
// Reset (synchronous): patterns all open, captures cleared via valid bits, channel 0.
module velocity_keyboard_matrix_scanner_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  vkms_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output vkms_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [vkms_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [vkms_pkg::CFG_W-1:0]         csr_data
);

   vkms_pkg::state_type state_ff, state_in;

   logic [vkms_pkg::CFG_W-1:0]       fast_ff, fast_in;
   logic [vkms_pkg::CFG_W-1:0]       slow_ff, slow_in;
   logic                             fixed_ff, fixed_in;
   logic [3:0]                       chan_ff, chan_in;
   logic [vkms_pkg::NUM_COLUMNS-1:0] pat_ff [vkms_pkg::NUM_ROWS];
   logic [vkms_pkg::NUM_COLUMNS-1:0] pat_in [vkms_pkg::NUM_ROWS];
   logic [vkms_pkg::PAIR_COUNT-1:0]  cap_valid_ff, cap_valid_in;

   logic [vkms_pkg::ROW_W-1:0]       row_ff, row_in;
   logic [vkms_pkg::NUM_COLUMNS-1:0] chg_ff, chg_in;
   logic [vkms_pkg::NUM_COLUMNS-1:0] bits_ff, bits_in;
   logic [vkms_pkg::TIME_WIDTH-1:0]  time_ff, time_in;
   logic [vkms_pkg::COL_W-1:0]       col_ff, col_in;
   logic [vkms_pkg::PAIR_W-1:0]      pair_ff, pair_in;

   vkms_pkg::rsp_type res_ff, res_in;
   vkms_pkg::rsp_type pend_ff, pend_in;
   logic              pend_valid_ff, pend_valid_in;
   vkms_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic                             ram_we;
   logic [vkms_pkg::PAIR_W-1:0]      ram_raddr;
   logic [vkms_pkg::TIME_WIDTH-1:0]  ram_rdata;
   vkms_pkg::div_req_type            div_req;
   vkms_pkg::div_rsp_type            div_rsp;

   logic                             out_free;
   logic [vkms_pkg::NUM_COLUMNS-1:0] req_chg;
   logic [vkms_pkg::PAIR_W-1:0]      pair;
   logic [vkms_pkg::PIN_W-1:0]       pin;
   logic [7:0]                       note_raw;
   logic [6:0]                       note;
   logic [vkms_pkg::COL_W-1:0]       ch_col;
   logic [vkms_pkg::TIME_WIDTH-1:0]  cap;
   logic [vkms_pkg::TIME_WIDTH-1:0]  delay;
   logic [vkms_pkg::TIME_WIDTH-1:0]  diff;
   logic [vkms_pkg::CFG_W-1:0]       span;
   logic [6:0]                       vel_idx;

   vkms_ram #(
      .WIDTH(vkms_pkg::TIME_WIDTH),
      .DEPTH(vkms_pkg::PAIR_COUNT)
   ) u_cap_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(pair),
      .wdata(time_ff),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   vkms_div u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pair     = {col_ff, row_ff[2:1]};
   assign pin      = {col_ff, row_ff[2:0]};
   assign note_raw = vkms_pkg::NOTE_ROM[pin];
   assign note     = (note_raw > vkms_pkg::NOTE_MAX) ? 7'd127 : note_raw[6:0];
   assign ch_col   = col_ff - vkms_pkg::FIRST_CH_COL;
   assign cap      = cap_valid_ff[pair_ff] ? ram_rdata : '0;
   assign delay    = time_ff - cap;
   assign diff     = delay - vkms_pkg::TIME_WIDTH'(fast_ff);
   assign span     = slow_ff - fast_ff;
   assign vel_idx  = (div_rsp.quotient >= vkms_pkg::QUOT_SAT) ? vkms_pkg::VEL_IDX_MIN
                                                              : 7'd127 - div_rsp.quotient;

   always_comb begin
      req_chg = '0;
      if (req_data.row_index < vkms_pkg::ROW_W'(vkms_pkg::NUM_ROWS)) begin
         req_chg = req_data.contact_bits ^ pat_ff[req_data.row_index];
      end
   end

   always_comb begin
      state_in      = state_ff;
      fast_in       = fast_ff;
      slow_in       = slow_ff;
      fixed_in      = fixed_ff;
      chan_in       = chan_ff;
      pat_in        = pat_ff;
      cap_valid_in  = cap_valid_ff;
      row_in        = row_ff;
      chg_in        = chg_ff;
      bits_in       = bits_ff;
      time_in       = time_ff;
      col_in        = col_ff;
      pair_in       = pair_ff;
      res_in        = res_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      ram_we        = 1'b0;
      ram_raddr     = pair;
      div_req       = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         case (csr_index)
            vkms_pkg::CSR_FASTEST: fast_in  = csr_data;
            vkms_pkg::CSR_SLOWEST: slow_in  = csr_data;
            vkms_pkg::CSR_FIXED:   fixed_in = csr_data[0];
            default: ;
         endcase
      end

      case (state_ff)
         vkms_pkg::ST_IDLE: begin
            if (req_valid && (req_chg != '0)) begin
               pat_in[req_data.row_index] = req_data.contact_bits;
               row_in   = req_data.row_index;
               chg_in   = req_chg;
               bits_in  = req_data.contact_bits;
               time_in  = req_data.time_ms;
               col_in   = '0;
               state_in = vkms_pkg::ST_SCAN;
            end
         end
         vkms_pkg::ST_SCAN: begin
            if (chg_ff == '0) begin
               state_in = vkms_pkg::ST_FLUSH;
            end else begin
               chg_in  = chg_ff >> 1;
               bits_in = bits_ff >> 1;
               col_in  = col_ff + 1'b1;
               if (chg_ff[0]) begin
                  if (row_ff == vkms_pkg::CHANNEL_ROW) begin
                     if (col_ff >= vkms_pkg::FIRST_CH_COL) begin
                        chan_in = vkms_pkg::CHAN_ROM[ch_col[3:0]];
                     end
                  end else if (!row_ff[3]) begin
                     if (!bits_ff[0]) begin
                        ram_we             = 1'b1;
                        cap_valid_in[pair] = 1'b1;
                     end else begin
                        cap_valid_in[pair] = 1'b0;
                        res_in.key_note     = note;
                        res_in.velocity_out = '0;
                        res_in.midi_channel = chan_ff;
                        res_in.last_of_row  = 1'b0;
                        state_in            = vkms_pkg::ST_EMIT;
                     end
                  end else if (!bits_ff[0]) begin
                     pair_in             = pair;
                     res_in.key_note     = note;
                     res_in.midi_channel = chan_ff;
                     res_in.last_of_row  = 1'b0;
                     state_in            = vkms_pkg::ST_READ;
                  end
               end
            end
         end
         vkms_pkg::ST_READ: begin
            if (cap == '0) begin
               state_in = vkms_pkg::ST_SCAN;
            end else if (fixed_ff || (delay <= vkms_pkg::TIME_WIDTH'(fast_ff))
                         || (slow_ff <= fast_ff)) begin
               res_in.velocity_out = vkms_pkg::VEL_ROM[vkms_pkg::VEL_IDX_MAX];
               state_in            = vkms_pkg::ST_EMIT;
            end else if (diff >= vkms_pkg::TIME_WIDTH'(span)) begin
               res_in.velocity_out = vkms_pkg::VEL_ROM[vkms_pkg::VEL_IDX_MIN];
               state_in            = vkms_pkg::ST_EMIT;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = {diff[vkms_pkg::CFG_W-1:0], {(vkms_pkg::QUOT_W){1'b0}}}
                                  - vkms_pkg::DIVIDEND_W'(diff[vkms_pkg::CFG_W-1:0]);
               div_req.divisor  = span;
               state_in         = vkms_pkg::ST_DIV;
            end
         end
         vkms_pkg::ST_DIV: begin
            if (div_rsp.done) begin
               res_in.velocity_out = vkms_pkg::VEL_ROM[vel_idx];
               state_in            = vkms_pkg::ST_EMIT;
            end
         end
         vkms_pkg::ST_EMIT: begin
            if (!pend_valid_ff) begin
               pend_in       = res_ff;
               pend_valid_in = 1'b1;
               state_in      = vkms_pkg::ST_SCAN;
            end else if (out_free) begin
               rsp_in        = pend_ff;
               rsp_valid_in  = 1'b1;
               pend_in       = res_ff;
               state_in      = vkms_pkg::ST_SCAN;
            end
         end
         vkms_pkg::ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = vkms_pkg::ST_IDLE;
            end else if (out_free) begin
               rsp_in             = pend_ff;
               rsp_in.last_of_row = 1'b1;
               rsp_valid_in       = 1'b1;
               pend_valid_in      = 1'b0;
               state_in           = vkms_pkg::ST_IDLE;
            end
         end
         default: state_in = vkms_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= vkms_pkg::ST_IDLE;
         fast_ff       <= '0;
         slow_ff       <= vkms_pkg::CFG_W'(127);
         fixed_ff      <= 1'b0;
         chan_ff       <= '0;
         cap_valid_ff  <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < vkms_pkg::NUM_ROWS; i++) begin
            pat_ff[i] <= '1;
         end
      end else begin
         state_ff      <= state_in;
         fast_ff       <= fast_in;
         slow_ff       <= slow_in;
         fixed_ff      <= fixed_in;
         chan_ff       <= chan_in;
         cap_valid_ff  <= cap_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         pat_ff        <= pat_in;
      end
      row_ff  <= row_in;
      chg_ff  <= chg_in;
      bits_ff <= bits_in;
      time_ff <= time_in;
      col_ff  <= col_in;
      pair_ff <= pair_in;
      res_ff  <= res_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready = (state_ff == vkms_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vkms_pkg::ST_IDLE) |-> !pend_valid_ff)
      else $error("pending event left over while idle");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == vkms_pkg::ST_DIV))
      else $error("divider finished outside divide state");

   a_flush_marks_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vkms_pkg::ST_FLUSH) && pend_valid_ff && out_free
      |=> rsp_valid_ff && rsp_ff.last_of_row)
      else $error("flushed event not marked last of row");

endmodule

>>> tb/testbench.sv
// Testbench for the velocity keyboard matrix scanner: random row scans with bursts, gaps and
// output stalls, results checked against an in-bench scanner model.
// Depends on vkms_pkg and velocity_keyboard_matrix_scanner_unit.
`timescale 1ns / 1ps

module testbench;

   typedef struct {
      bit                 is_cfg;
      bit [1:0]           idx;
      bit [15:0]          val;
      vkms_pkg::req_type  scan;
   } pending_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic rsp_ready = 0;
   logic csr_valid = 0;
   logic [vkms_pkg::CSR_INDEX_W-1:0] csr_index = vkms_pkg::CSR_FASTEST;
   logic [vkms_pkg::CFG_W-1:0] csr_data = '0;
   vkms_pkg::req_type req_data = '0;
   logic req_ready, rsp_valid, csr_ready;
   vkms_pkg::rsp_type rsp_data;

   velocity_keyboard_matrix_scanner_unit u_top (.*);

   pending_type pending_q[$];
   vkms_pkg::rsp_type note_events_q[$];
   int mismatches = 0;
   bit driver_done = 0;

   // scanner model state
   bit [23:0] m_rows [17];
   bit [31:0] m_press [96];
   bit [3:0]  m_chan;
   bit [15:0] m_fast, m_slow;
   bit        m_fixed;

   function automatic bit [6:0] vel_index(bit [31:0] dly);
      bit [63:0] q;
      if (m_fixed || dly <= m_fast || m_slow <= m_fast) return 7'd127;
      q = (64'(dly - m_fast) * 127) / (m_slow - m_fast);
      if (q >= 126) return 7'd1;
      return 7'(127 - q);
   endfunction

   function automatic void scan_row(vkms_pkg::req_type r);
      bit [23:0] changed;
      bit [7:0] pin;
      bit [6:0] pair;
      vkms_pkg::rsp_type e;
      int n;
      n = 0;
      if (r.row_index >= 17) return;
      changed = r.contact_bits ^ m_rows[r.row_index];
      if (changed == 0) return;
      m_rows[r.row_index] = r.contact_bits;
      for (int c = 0; c < 24; c++) begin
         if (!changed[c]) continue;
         if (r.row_index == 16) begin
            if (c >= 8) m_chan = vkms_pkg::CHAN_ROM[c - 8];
            continue;
         end
         pin = 8'(c * 8 + r.row_index[2:0]);
         pair = pin[7:1];
         e.key_note = (vkms_pkg::NOTE_ROM[pin] > 127) ? 7'd127 : vkms_pkg::NOTE_ROM[pin][6:0];
         e.midi_channel = m_chan;
         e.last_of_row = 0;
         if (!r.contact_bits[c]) begin
            if (!r.row_index[3]) m_press[pair] = r.time_ms;
            else if (m_press[pair] != 0) begin
               e.velocity_out = vkms_pkg::VEL_ROM[vel_index(r.time_ms - m_press[pair])];
               note_events_q.push_back(e);
               n++;
            end
         end else if (!r.row_index[3]) begin
            m_press[pair] = 0;
            e.velocity_out = 0;
            note_events_q.push_back(e);
            n++;
         end
      end
      if (n > 0) note_events_q[$].last_of_row = 1;
   endfunction

   initial forever #10 clock = ~clock;

   initial begin
      #200000000;
      $display("Simulation FAILED");
      $finish;
   end

   // driver
   int gap = 0, burst = 0;
   bit cfg_wait = 0;
   int settle = 0;
   always @(posedge clock) begin
      if (reset) begin
      end else if (req_valid && req_ready) begin
         scan_row(req_data);
         req_valid <= 0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            vkms_pkg::CSR_FASTEST: m_fast = csr_data;
            vkms_pkg::CSR_SLOWEST: m_slow = csr_data;
            default:               m_fixed = csr_data[0];
         endcase
         csr_valid <= 0;
      end else if (!req_valid && !csr_valid) begin
         if (pending_q.size() == 0) driver_done <= 1;
         else if (pending_q[0].is_cfg) begin
            // hold until no note events are outstanding, then let the unit drain its last row
            if (note_events_q.size() != 0) settle <= 0;
            else if (settle < 300) settle <= settle + 1;
            else begin
               csr_index <= pending_q[0].idx;
               csr_data <= pending_q[0].val;
               csr_valid <= 1;
               void'(pending_q.pop_front());
            end
         end else if (gap > 0) gap <= gap - 1;
         else begin
            req_data <= pending_q[0].scan;
            req_valid <= 1;
            settle <= 0;
            void'(pending_q.pop_front());
            if (burst > 0) burst <= burst - 1;
            else begin
               burst <= $urandom_range(0, 6);
               gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end
         end
      end
   end

   // monitor
   int stall_phase = 0;
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      rsp_ready <= !reset && ((stall_phase % 64) < 32 || $urandom_range(0, 2) != 0);
      if (!reset && rsp_valid && rsp_ready) begin
         if (note_events_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected note event %p", rsp_data);
         end else begin
            if (rsp_data !== note_events_q[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p got %p", note_events_q[0], rsp_data);
            end
            void'(note_events_q.pop_front());
         end
      end
   end

   task automatic add_cfg(bit [1:0] i, bit [15:0] v);
      pending_type p;
      p.is_cfg = 1; p.idx = i; p.val = v; p.scan = '0;
      pending_q.push_back(p);
   endtask

   task automatic add_scan(bit [4:0] row, bit [23:0] bits, bit [31:0] t);
      pending_type p;
      p.is_cfg = 0; p.idx = 0; p.val = 0;
      p.scan.row_index = row; p.scan.contact_bits = bits; p.scan.time_ms = t;
      pending_q.push_back(p);
   endtask

   // press and release one or two keys of one row pair with random timing
   task automatic add_keystrokes(int cnt);
      bit [2:0] r;
      bit [23:0] cols;
      bit [31:0] t;
      r = 3'($urandom_range(0, 7));
      cols = ~(24'(1) << $urandom_range(0, 23));
      if ($urandom_range(0, 1)) cols &= ~(24'(1) << $urandom_range(0, 23));
      t = $urandom;
      if ($urandom_range(0, 3) == 0) t = 0;
      for (int i = 0; i < cnt; i++) begin
         add_scan({2'b00, r}, cols, t);
         t += $urandom_range(0, 300);
         add_scan({2'b01, r}, cols, t);
         add_scan({2'b01, r}, 24'hffffff, t);
         add_scan({2'b00, r}, 24'hffffff, t + 1);
      end
   endtask

   initial begin
      m_rows = '{default: 24'hffffff};
      m_press = '{default: 0};
      m_chan = 0; m_fast = 0; m_slow = 127; m_fixed = 0;
      repeat (4) @(posedge clock);
      reset <= 0;

      add_scan(5'd0, 24'h000000, 32'd100);
      add_scan(5'd8, 24'h000000, 32'd100);
      add_scan(5'd8, 24'hffffff, 32'd150);
      add_scan(5'd8, 24'h000000, 32'hffffffff);
      add_scan(5'd0, 24'hffffff, 32'd0);
      add_scan(5'd0, 24'hffffff, 32'd5);
      add_scan(5'd7, 24'hfffffe, 32'hfffffff0);
      add_scan(5'd15, 24'hfffffe, 32'd20);
      add_scan(5'd15, 24'h555555, 32'd40);
      add_scan(5'd16, 24'h00ff00, 32'd0);
      add_scan(5'd16, 24'hff0000, 32'd0);
      add_scan(5'd17, 24'h000000, 32'd1);
      add_scan(5'd31, 24'h123456, 32'd1);
      add_scan(5'd3, 24'h000000, 32'd0);
      add_scan(5'd11, 24'h000000, 32'd9);
      add_scan(5'd3, 24'hffffff, 32'd9);
      add_scan(5'd7, 24'hffffff, 32'd9);

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin add_cfg(vkms_pkg::CSR_FASTEST, 16'd0);
                     add_cfg(vkms_pkg::CSR_SLOWEST, 16'd127);
                     add_cfg(vkms_pkg::CSR_FIXED, 16'd1); end
            1: begin add_cfg(vkms_pkg::CSR_FIXED, 16'd0);
                     add_cfg(vkms_pkg::CSR_FASTEST, 16'd10);
                     add_cfg(vkms_pkg::CSR_SLOWEST, 16'd250); end
            2: begin add_cfg(vkms_pkg::CSR_FASTEST, 16'hffff);
                     add_cfg(vkms_pkg::CSR_SLOWEST, 16'hffff); end
            3: begin add_cfg(vkms_pkg::CSR_FASTEST, 16'd0);
                     add_cfg(vkms_pkg::CSR_SLOWEST, 16'hffff); end
            default: begin add_cfg(vkms_pkg::CSR_FASTEST, 16'd200);
                           add_cfg(vkms_pkg::CSR_SLOWEST, 16'd5); end
         endcase
         for (int k = 0; k < 4; k++) begin
            add_keystrokes(1);
            if ($urandom_range(0, 2) == 0)
               add_scan(5'($urandom_range(0, 16)), 24'($urandom), $urandom);
            if ($urandom_range(0, 5) == 0)
               add_scan(5'($urandom_range(0, 31)), 24'($urandom), $urandom);
         end
      end

      wait (driver_done && note_events_q.size() == 0);
      repeat (400) @(posedge clock);
      if (mismatches == 0 && note_events_q.size() == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule

>>> sim.f
hdl/vkms_pkg.sv
hdl/vkms_ram.sv
hdl/vkms_div.sv
hdl/velocity_keyboard_matrix_scanner_unit.sv
tb/testbench.sv
